/* hdl/bsc_pkg.sv */
// shared types, constants and latencies of the barometric compensation pipeline
package bsc_pkg;

  localparam int unsigned RawW    = 20;
  localparam int unsigned TrimW   = 48;
  localparam int unsigned FineW   = 32;
  localparam int unsigned DivW    = 64;
  localparam int unsigned TempLat = 4;
  localparam int unsigned PreLat  = 6;
  localparam int unsigned DivLat  = DivW + 2;
  localparam int unsigned PostLat = 5;
  localparam int unsigned TotalLat = TempLat + PreLat + DivLat + PostLat;

  localparam logic signed [33:0] FineOffset = 34'sd128000;
  localparam logic [20:0]        PressFull  = 21'd1048576;
  localparam logic [11:0]        PressScale = 12'd3125;
  localparam logic signed [63:0] OneQ47     = 64'sh0000_8000_0000_0000;
  localparam logic signed [31:0] TempMul    = 32'sd5;
  localparam logic signed [31:0] TempRound  = 32'sd128;

  typedef enum logic [1:0] {
    RegTempTrim   = 2'd0,
    RegPressTrimA = 2'd1,
    RegPressTrimB = 2'd2,
    RegPressTrimC = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } trim_t;

endpackage

/* hdl/bsc_temp.sv */
// temperature stages: fine temperature value from the raw reading
module bsc_temp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [19:0]              raw_temp_i,
  input  logic [19:0]              raw_press_i,
  input  bsc_pkg::trim_t           trim_i,
  output logic                     valid_o,
  output logic signed [31:0]       tfine_o,
  output logic [19:0]              raw_press_o
);

  logic [bsc_pkg::TempLat-1:0] valid_q;
  logic [19:0]                 press_q [bsc_pkg::TempLat];

  logic signed [17:0] x_d, x_q;
  logic signed [16:0] d_d, d_q;
  logic signed [33:0] pa, pd;
  logic signed [35:0] pb;
  logic signed [31:0] a_d, a_q, a2_q;
  logic signed [19:0] dd_d, dd_q;
  logic signed [31:0] b_d, b_q;
  logic signed [31:0] tfine_d, tfine_q;

  always_comb begin
    x_d     = $signed({1'b0, raw_temp_i[19:3]}) - $signed({1'b0, trim_i.t1, 1'b0});
    d_d     = $signed({1'b0, raw_temp_i[19:4]}) - $signed({1'b0, trim_i.t1});
    pa      = x_q * $signed(trim_i.t2);
    pd      = d_q * d_q;
    a_d     = $signed(pa[31:0]) >>> 11;
    dd_d    = 20'($signed(pd[31:0]) >>> 12);
    pb      = dd_q * $signed(trim_i.t3);
    b_d     = $signed(pb[31:0]) >>> 14;
    tfine_d = a2_q + b_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[bsc_pkg::TempLat-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    d_q     <= d_d;
    a_q     <= a_d;
    dd_q    <= dd_d;
    a2_q    <= a_q;
    b_q     <= b_d;
    tfine_q <= tfine_d;
    press_q[0] <= raw_press_i;
    for (int k = 1; k < bsc_pkg::TempLat; k++) begin
      press_q[k] <= press_q[k-1];
    end
  end

  assign valid_o     = valid_q[bsc_pkg::TempLat-1];
  assign tfine_o     = tfine_q;
  assign raw_press_o = press_q[bsc_pkg::TempLat-1];

endmodule

/* hdl/bsc_ppre.sv */
// pressure stages before the division: dividend and divisor
module bsc_ppre (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic signed [31:0] tfine_i,
  input  logic [19:0]        raw_press_i,
  input  bsc_pkg::trim_t     trim_i,
  output logic               valid_o,
  output logic signed [63:0] num_o,
  output logic signed [63:0] den_o,
  output logic signed [31:0] tfine_o
);

  logic [bsc_pkg::PreLat-1:0] valid_q;
  logic [31:0]                tf_q [bsc_pkg::PreLat];

  logic signed [33:0] v1_d, v1_q;
  logic [20:0]        pd1_q, pd2_q, pd3_q, pd4_q;
  logic signed [67:0] sqf;
  logic signed [49:0] v5_d, v5_q, v5b_q;
  logic signed [49:0] v2m_d, v2m_q, v2mb_q;
  logic signed [63:0] sq_q;
  logic signed [79:0] m6, m3;
  logic signed [63:0] t6_q, t3_q;
  logic signed [63:0] v2_d, v2_q, v1b_d, v1b_q;
  logic signed [63:0] v1s;
  logic signed [80:0] m1;
  logic signed [63:0] v1p_q, xn_d, xn_q;
  logic signed [76:0] mn;
  logic signed [63:0] num_q, den_q;

  always_comb begin
    v1_d  = $signed({{2{tfine_i[31]}}, tfine_i}) - bsc_pkg::FineOffset;
    sqf   = v1_q * v1_q;
    v5_d  = v1_q * $signed(trim_i.p5);
    v2m_d = v1_q * $signed(trim_i.p2);
    m6    = sq_q * $signed(trim_i.p6);
    m3    = sq_q * $signed(trim_i.p3);
    v2_d  = t6_q + ($signed({{14{v5b_q[49]}}, v5b_q}) <<< 17)
          + ($signed({{48{trim_i.p4[15]}}, trim_i.p4}) <<< 35);
    v1b_d = (t3_q >>> 8) + ($signed({{14{v2mb_q[49]}}, v2mb_q}) <<< 12);
    v1s   = v1b_q + bsc_pkg::OneQ47;
    m1    = v1s * $signed({1'b0, trim_i.p1});
    xn_d  = $signed({12'b0, pd4_q, 31'b0}) - v2_q;
    mn    = xn_q * $signed({1'b0, bsc_pkg::PressScale});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[bsc_pkg::PreLat-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    v1_q   <= v1_d;
    pd1_q  <= bsc_pkg::PressFull - {1'b0, raw_press_i};
    sq_q   <= sqf[63:0];
    v5_q   <= v5_d;
    v2m_q  <= v2m_d;
    pd2_q  <= pd1_q;
    t6_q   <= m6[63:0];
    t3_q   <= m3[63:0];
    v5b_q  <= v5_q;
    v2mb_q <= v2m_q;
    pd3_q  <= pd2_q;
    v2_q   <= v2_d;
    v1b_q  <= v1b_d;
    pd4_q  <= pd3_q;
    v1p_q  <= m1[63:0];
    xn_q   <= xn_d;
    den_q  <= v1p_q >>> 33;
    num_q  <= mn[63:0];
    tf_q[0] <= tfine_i;
    for (int k = 1; k < bsc_pkg::PreLat; k++) begin
      tf_q[k] <= tf_q[k-1];
    end
  end

  assign valid_o = valid_q[bsc_pkg::PreLat-1];
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign tfine_o = $signed(tf_q[bsc_pkg::PreLat-1]);

endmodule

/* hdl/bsc_div.sv */
// pipelined signed divider, one quotient bit per stage, truncating
module bsc_div #(
  parameter int unsigned TagW = bsc_pkg::FineW
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic signed [63:0]  num_i,
  input  logic signed [63:0]  den_i,
  input  logic [TagW-1:0]     tag_i,
  output logic                valid_o,
  output logic [63:0]         quot_o,
  output logic                zero_o,
  output logic [TagW-1:0]     tag_o
);

  localparam int unsigned W  = bsc_pkg::DivW;
  localparam int unsigned SW = TagW + 2;

  logic [W:0]    valid_q;
  logic [W-1:0]  rem_q  [W+1];
  logic [W-1:0]  quo_q  [W+1];
  logic [W-1:0]  dvs_q  [W+1];
  logic [SW-1:0] side_q [W+1];

  logic            out_valid_q;
  logic [W-1:0]    quot_q;
  logic            zero_q;
  logic [TagW-1:0] tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q     <= {valid_q[W-1:0], valid_i};
      out_valid_q <= valid_q[W];
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= '0;
    quo_q[0]  <= num_i[W-1] ? 64'(-num_i) : 64'(num_i);
    dvs_q[0]  <= den_i[W-1] ? 64'(-den_i) : 64'(den_i);
    side_q[0] <= {num_i[W-1] ^ den_i[W-1], den_i == '0, tag_i};
  end

  for (genvar k = 1; k <= W; k++) begin : g_step
    logic [W:0] trial;
    logic [W:0] diff;
    logic       take;

    assign trial = {rem_q[k-1], quo_q[k-1][W-1]};
    assign diff  = trial - {1'b0, dvs_q[k-1]};
    assign take  = trial >= {1'b0, dvs_q[k-1]};

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= take ? diff[W-1:0] : trial[W-1:0];
      quo_q[k]  <= {quo_q[k-1][W-2:0], take};
      dvs_q[k]  <= dvs_q[k-1];
      side_q[k] <= side_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= side_q[W][SW-1] ? (~quo_q[W] + 64'd1) : quo_q[W];
    zero_q <= side_q[W][SW-2];
    tag_q  <= side_q[W][TagW-1:0];
  end

  assign valid_o = out_valid_q;
  assign quot_o  = quot_q;
  assign zero_o  = zero_q;
  assign tag_o   = tag_q;

endmodule

/* hdl/bsc_ppost.sv */
// pressure stages after the division and the temperature result
module bsc_ppost (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [63:0]        quot_i,
  input  logic               zero_i,
  input  logic signed [31:0] tfine_i,
  input  bsc_pkg::trim_t     trim_i,
  output logic               valid_o,
  output logic signed [31:0] temp_o,
  output logic [31:0]        press_o,
  output logic               invalid_o
);

  localparam int unsigned TagN = bsc_pkg::PostLat - 1;

  logic [bsc_pkg::PostLat-1:0] valid_q;
  logic [31:0]                 tf_q  [TagN];
  logic [TagN-1:0]             inv_q;

  logic signed [63:0] ps;
  logic signed [24:0] h;
  logic [25:0]        l;
  logic signed [49:0] hh_q;
  logic signed [51:0] hl_q;
  logic [51:0]        ll_q;
  logic signed [79:0] m8, m9;
  logic signed [63:0] w2p_q, w2_q, w2b_q;
  logic signed [63:0] q1_q, q2_q, q3_q;
  logic [63:0]        sq_d, sq_q;
  logic signed [63:0] w1p_q;
  logic signed [63:0] sum_d, sum_q;
  logic signed [63:0] pr;
  logic signed [31:0] tm5;
  logic signed [31:0] temp_q;
  logic [31:0]        press_q;
  logic               invalid_q;

  always_comb begin
    ps    = $signed(quot_i) >>> 13;
    h     = ps[50:26];
    l     = ps[25:0];
    m8    = $signed(quot_i) * $signed(trim_i.p8);
    sq_d  = {hh_q[11:0], 52'b0} + {hl_q[36:0], 27'b0} + {12'b0, ll_q};
    m9    = $signed(sq_q) * $signed(trim_i.p9);
    sum_d = q3_q + (w1p_q >>> 25) + w2b_q;
    pr    = (sum_q >>> 8) + ($signed({{48{trim_i.p7[15]}}, trim_i.p7}) <<< 4);
    tm5   = $signed(tf_q[TagN-1]) * bsc_pkg::TempMul + bsc_pkg::TempRound;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[bsc_pkg::PostLat-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    hh_q  <= h * h;
    hl_q  <= h * $signed({1'b0, l});
    ll_q  <= l * l;
    w2p_q <= m8[63:0];
    q1_q  <= $signed(quot_i);
    sq_q  <= sq_d;
    w2_q  <= w2p_q >>> 19;
    q2_q  <= q1_q;
    w1p_q <= m9[63:0];
    w2b_q <= w2_q;
    q3_q  <= q2_q;
    sum_q <= sum_d;
    temp_q    <= tm5 >>> 8;
    press_q   <= inv_q[TagN-1] ? 32'd0 : pr[31:0];
    invalid_q <= inv_q[TagN-1];
    tf_q[0] <= tfine_i;
    for (int k = 1; k < TagN; k++) begin
      tf_q[k] <= tf_q[k-1];
    end
    inv_q <= {inv_q[TagN-2:0], zero_i};
  end

  assign valid_o   = valid_q[bsc_pkg::PostLat-1];
  assign temp_o    = temp_q;
  assign press_o   = press_q;
  assign invalid_o = invalid_q;

endmodule

/* hdl/barometric_sensor_compensation.sv */
// barometric compensation top level: trim registers, pipeline and result strobe
// pipeline: a word accepted at one edge passes through
//   4 temperature, 6 pre-division, 66 divider and 5 post-division stages to its result
// throughput: one word per cycle, busy stays low; the divider yields one bit per stage
// reset: asynchronous, active low; clears trims and all valid bits
// results last one cycle on result_valid_o and cannot be stalled
module barometric_sensor_compensation (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [19:0]        raw_temp_i,
  input  logic [19:0]        raw_press_i,
  output logic               result_valid_o,
  output logic signed [31:0] temp_centi_c_o,
  output logic [31:0]        press_q24_8_o,
  output logic               press_invalid_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  logic [47:0] temp_trim_q, press_a_q, press_b_q, press_c_q;
  logic        wr_en;
  bsc_pkg::reg_idx_e idx;
  bsc_pkg::trim_t    trim;

  logic               t_valid;
  logic signed [31:0] t_fine;
  logic [19:0]        t_press;
  logic               p_valid;
  logic signed [63:0] p_num, p_den;
  logic signed [31:0] p_fine;
  logic               d_valid;
  logic [63:0]        d_quot;
  logic               d_zero;
  logic [31:0]        d_fine;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = bsc_pkg::reg_idx_e'(paddr[4:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_trim_q <= '0;
      press_a_q   <= '0;
      press_b_q   <= '0;
      press_c_q   <= '0;
    end else if (wr_en) begin
      unique case (idx)
        bsc_pkg::RegTempTrim:   temp_trim_q <= pwdata[47:0];
        bsc_pkg::RegPressTrimA: press_a_q   <= pwdata[47:0];
        bsc_pkg::RegPressTrimB: press_b_q   <= pwdata[47:0];
        bsc_pkg::RegPressTrimC: press_c_q   <= pwdata[47:0];
        default:                temp_trim_q <= temp_trim_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bsc_pkg::RegTempTrim:   prdata = {16'b0, temp_trim_q};
      bsc_pkg::RegPressTrimA: prdata = {16'b0, press_a_q};
      bsc_pkg::RegPressTrimB: prdata = {16'b0, press_b_q};
      bsc_pkg::RegPressTrimC: prdata = {16'b0, press_c_q};
      default:                prdata = '0;
    endcase
  end

  always_comb begin
    trim.t1 = temp_trim_q[15:0];
    trim.t2 = temp_trim_q[31:16];
    trim.t3 = temp_trim_q[47:32];
    trim.p1 = press_a_q[15:0];
    trim.p2 = press_a_q[31:16];
    trim.p3 = press_a_q[47:32];
    trim.p4 = press_b_q[15:0];
    trim.p5 = press_b_q[31:16];
    trim.p6 = press_b_q[47:32];
    trim.p7 = press_c_q[15:0];
    trim.p8 = press_c_q[31:16];
    trim.p9 = press_c_q[47:32];
  end

  bsc_temp u_temp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (start && !busy),
    .raw_temp_i  (raw_temp_i),
    .raw_press_i (raw_press_i),
    .trim_i      (trim),
    .valid_o     (t_valid),
    .tfine_o     (t_fine),
    .raw_press_o (t_press)
  );

  bsc_ppre u_ppre (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (t_valid),
    .tfine_i     (t_fine),
    .raw_press_i (t_press),
    .trim_i      (trim),
    .valid_o     (p_valid),
    .num_o       (p_num),
    .den_o       (p_den),
    .tfine_o     (p_fine)
  );

  bsc_div #(
    .TagW (bsc_pkg::FineW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p_valid),
    .num_i   (p_num),
    .den_i   (p_den),
    .tag_i   (p_fine),
    .valid_o (d_valid),
    .quot_o  (d_quot),
    .zero_o  (d_zero),
    .tag_o   (d_fine)
  );

  bsc_ppost u_ppost (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (d_valid),
    .quot_i    (d_quot),
    .zero_i    (d_zero),
    .tfine_i   ($signed(d_fine)),
    .trim_i    (trim),
    .valid_o   (result_valid_o),
    .temp_o    (temp_centi_c_o),
    .press_o   (press_q24_8_o),
    .invalid_o (press_invalid_o)
  );

  // every accepted word comes out after the fixed pipeline depth
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(bsc_pkg::TotalLat) result_valid_o)
    else $error("accepted word did not emerge at the pipeline depth");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !$past(start && !busy, bsc_pkg::TotalLat)) |-> 1'b0)
    else $error("result word without an accepted input");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && press_invalid_o) |-> (press_q24_8_o == 32'd0))
    else $error("pressure not zero for a zero divisor");

endmodule
